[sv/joystick_drive_frame_encoder_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the joystick drive frame encoder
// Short wrappers for clocked implication checks that reset disables.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_DRIVE_FRAME_ENCODER_ASSERT_SVH
`define JOYSTICK_DRIVE_FRAME_ENCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JDFE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("jdfe same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define JDFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("jdfe next-cycle check failed");

`endif

[sv/jdfe_pkg.sv]
// ----------------------------------------------------------------------------
// Joystick drive frame encoder package
// Shared types, opcodes, frame constants and byte helpers.
// ----------------------------------------------------------------------------
package jdfe_pkg;

    // Frame geometry.
    localparam int FRAME_MAX = 11;
    localparam int CNT_W     = $clog2(FRAME_MAX + 1);

    localparam logic [CNT_W-1:0] POWERUP_LEN = CNT_W'(11);
    localparam logic [CNT_W-1:0] DRIVE_LEN   = CNT_W'(10);

    // Fixed byte values.
    localparam logic [7:0] FRAME_END     = 8'd15;
    localparam logic [7:0] DRIVE_HEADER  = 8'h60;
    localparam logic [7:0] MARK_BIT      = 8'd128;
    localparam logic [7:0] DRIVE_HORN    = 8'd128;
    localparam logic [7:0] DRIVE_ON      = 8'd132;
    localparam logic [7:0] DRIVE_MODE    = 8'd128;
    localparam logic [7:0] CHECK_BASE_PU = 8'h7f;
    localparam logic [7:0] CHECK_BASE_DR = 8'd255;

    localparam logic [7:0] POWERUP_BYTES [9] = '{
        8'h74, 8'd130, 8'd133, 8'd130, 8'd128, 8'd136, 8'd205, 8'd160, 8'd128
    };

    // Request opcodes.
    typedef enum logic {
        OP_POWERUP = 1'b0,
        OP_DRIVE   = 1'b1
    } t_op;

    // One complete frame, byte 0 sent first.
    typedef struct packed {
        logic [FRAME_MAX-1:0][7:0] bytes;
        logic [CNT_W-1:0]          len;
    } t_frame;

    // Power-up checksum, worked out at elaboration.
    function automatic logic [7:0] powerup_check();
        logic [7:0] sum;
        sum = 8'd0;
        for (int k = 0; k < 9; k++) begin
            sum = sum + {1'b0, POWERUP_BYTES[k][6:0]};
        end
        return CHECK_BASE_PU - sum;
    endfunction

    // Scale 0..255 to 0..1023 as x*1023/255 rounded down.
    // x*1023/255 = 4x + floor(3x/255), and the second term is at most 3.
    function automatic logic [9:0] scale_ten(input logic [7:0] x);
        logic [1:0] frac;
        if (x == 8'd255) begin
            frac = 2'd3;
        end else if (x >= 8'd170) begin
            frac = 2'd2;
        end else if (x >= 8'd85) begin
            frac = 2'd1;
        end else begin
            frac = 2'd0;
        end
        return {x, 2'b00} + {8'd0, frac};
    endfunction

endpackage

[sv/jdfe_req_if.sv]
// ----------------------------------------------------------------------------
// Frame request channel
// Valid/ready channel that carries one frame request.
// ----------------------------------------------------------------------------
interface jdfe_req_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] speed_value;
    logic [7:0] direction_value;

    modport source (output valid, output op, output speed_value,
                    output direction_value, input ready);
    modport sink   (input valid, input op, input speed_value,
                    input direction_value, output ready);
endinterface

[sv/jdfe_byte_if.sv]
// ----------------------------------------------------------------------------
// Frame byte channel
// Valid/ready channel that carries one frame byte and its last flag.
// ----------------------------------------------------------------------------
interface jdfe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

[sv/jdfe_cfg_if.sv]
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that writes the maximum speed setting.
// ----------------------------------------------------------------------------
interface jdfe_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/jdfe_frame_build.sv]
// ----------------------------------------------------------------------------
// Frame builder
// Forms every byte of a power-up or drive frame from one registered request.
// ----------------------------------------------------------------------------
module jdfe_frame_build
    import jdfe_pkg::*;
(
    input  t_op        i_op,
    input  logic [7:0] i_speed_value,
    input  logic [7:0] i_direction_value,
    input  logic [7:0] i_max_speed,
    output t_frame     o_frame
);

    localparam logic [7:0] PU_CHECK = powerup_check();

    logic [9:0] spd;
    logic [9:0] dir;
    logic [7:0] drv [8];
    logic [6:0] sum7;

    // Scaled readings.
    assign spd = scale_ten(i_speed_value);
    assign dir = scale_ten(i_direction_value);

    // Drive frame body.
    assign drv[0] = DRIVE_HEADER;
    assign drv[1] = MARK_BIT | {1'b0, spd[9:3]};
    assign drv[2] = MARK_BIT | {1'b0, dir[9:3]};
    assign drv[3] = MARK_BIT | {1'b0, i_max_speed[7:1]};
    assign drv[4] = MARK_BIT | {1'b0, i_max_speed[0], spd[2:0], dir[2:0]};
    assign drv[5] = DRIVE_HORN;
    assign drv[6] = DRIVE_ON;
    assign drv[7] = DRIVE_MODE;

    // Drive checksum: seven-bit sum of the low bits of the body bytes.
    assign sum7 = drv[0][6:0] + drv[1][6:0] + drv[2][6:0] + drv[3][6:0]
                + drv[4][6:0] + drv[5][6:0] + drv[6][6:0] + drv[7][6:0];

    // Frame selection.
    always_comb begin
        o_frame = '0;
        unique case (i_op)
            OP_POWERUP: begin
                for (int k = 0; k < 9; k++) begin
                    o_frame.bytes[k] = POWERUP_BYTES[k];
                end
                o_frame.bytes[9]  = PU_CHECK;
                o_frame.bytes[10] = FRAME_END;
                o_frame.len       = POWERUP_LEN;
            end
            OP_DRIVE: begin
                for (int k = 0; k < 8; k++) begin
                    o_frame.bytes[k] = drv[k];
                end
                o_frame.bytes[8] = CHECK_BASE_DR - {1'b0, sum7};
                o_frame.bytes[9] = FRAME_END;
                o_frame.len      = DRIVE_LEN;
            end
            default: begin
                o_frame = '0;
            end
        endcase
    end

endmodule

[sv/joystick_drive_frame_encoder.sv]
// ----------------------------------------------------------------------------
// Joystick drive frame encoder
// Turns frame requests into serial byte frames, one byte per handshake.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  i_req     in         op, speed_value, direction_value
//  o_rsp     out        frame_byte, last_byte
//  i_cfg     in         data (maximum speed setting)
//
//  A power-up request yields 11 bytes, a drive request 10, one per cycle while o_rsp is ready.
//  The output shift register sets the rate: one request per frame, loaded as the last byte goes.
//  The next request is taken into the input register while a frame streams.
//  Reset clears the valid flags and sets the maximum speed setting to zero.
//  A stalled output holds its byte; the input waits while both stages are full.
// ----------------------------------------------------------------------------
`include "joystick_drive_frame_encoder_assert.svh"

module joystick_drive_frame_encoder
    import jdfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    jdfe_req_if.sink    i_req,
    jdfe_cfg_if.sink    i_cfg,
    jdfe_byte_if.source o_rsp
);

    logic                      r_in_vld;
    t_op                       r_in_op;
    logic [7:0]                r_in_spd;
    logic [7:0]                r_in_dir;
    logic [7:0]                r_max;
    logic                      r_busy;
    logic [CNT_W-1:0]          r_cnt;
    logic [FRAME_MAX-1:0][7:0] r_bytes;

    logic   out_fire;
    logic   fin;
    logic   load;
    t_frame built;

    // Handshake decode.
    assign out_fire = r_busy && o_rsp.ready;
    assign fin      = out_fire && (r_cnt == CNT_W'(1));
    assign load     = r_in_vld && (!r_busy || fin);

    assign i_req.ready = !r_in_vld || load;
    assign i_cfg.ready = 1'b1;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= 8'd0;
        end else if (i_cfg.valid) begin
            r_max <= i_cfg.data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_vld <= 1'b1;
        end else if (load) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_op  <= t_op'(i_req.op);
            r_in_spd <= i_req.speed_value;
            r_in_dir <= i_req.direction_value;
        end
    end

    // Frame contents for the held request.
    jdfe_frame_build u_build (
        .i_op              (r_in_op),
        .i_speed_value     (r_in_spd),
        .i_direction_value (r_in_dir),
        .i_max_speed       (r_max),
        .o_frame           (built)
    );

    // Output shift register and byte count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_cnt  <= built.len;
        end else if (out_fire) begin
            r_busy <= !fin;
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bytes <= built.bytes;
        end else if (out_fire) begin
            r_bytes <= {8'h00, r_bytes[FRAME_MAX-1:1]};
        end
    end

    assign o_rsp.valid      = r_busy;
    assign o_rsp.frame_byte = r_bytes[0];
    assign o_rsp.last_byte  = (r_cnt == CNT_W'(1));

    // Checks.
    `JDFE_ASSERT_SAME(a_busy_has_bytes, i_clk, i_rst_n, r_busy, r_cnt != '0)
    `JDFE_ASSERT_SAME(a_last_is_end, i_clk, i_rst_n, r_busy && o_rsp.last_byte, r_bytes[0] == FRAME_END)
    `JDFE_ASSERT_NEXT(a_idle_after_end, i_clk, i_rst_n, fin && !r_in_vld, !r_busy)
    `JDFE_ASSERT_NEXT(a_held_request, i_clk, i_rst_n, r_in_vld && !load, r_in_vld && $stable(r_in_op))

endmodule
